>>> rtl/core/dmrbs_pkg.sv
// ----------------------------------------------------------------------------
// dmrbs_pkg
// Types, codes, field layout and reset values for the dual motor ramp and
// brake sequencer.
// ----------------------------------------------------------------------------
package dmrbs_pkg;

    localparam int DUTY_W  = 15;
    localparam int SPEED_W = 16;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_PROCESS = 3'd1,
        FUNC_COMMAND = 3'd2,
        FUNC_RESET   = 3'd3,
        FUNC_SPEEDS  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_DONE    = 2'd1,
        EV_TIMEOUT = 2'd2
    } event_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PWM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOPPED_RPM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 3'd5;

    localparam logic [14:0] RST_MAX_PWM     = 15'd255;
    localparam logic [14:0] RST_RAMP_STEP   = 15'd10;
    localparam logic [15:0] RST_BRAKE_MS    = 16'd100;
    localparam logic [14:0] RST_STOPPED_RPM = 15'd1;
    localparam logic [30:0] RST_MIN_PULSES  = 31'd10;
    localparam logic [15:0] RST_TIMEOUT_MS  = 16'd1000;

    // s_tdata layout
    localparam int IN_NOW_LO   = 0;
    localparam int IN_LVAL_LO  = 32;
    localparam int IN_RVAL_LO  = 48;
    localparam int IN_RAMP_EN  = 64;
    localparam int IN_ABS_BRK  = 65;
    localparam int IN_LCNT_LO  = 66;
    localparam int IN_RCNT_LO  = 98;
    localparam int IN_LRPM_LO  = 130;
    localparam int IN_RRPM_LO  = 146;
    localparam int IN_DEMO     = 162;
    localparam int IN_DATA_W   = 168;
    localparam int OUT_DATA_W  = 72;

    function automatic logic signed [SPEED_W-1:0] clamp_speed(
        input logic signed [SPEED_W-1:0] v,
        input logic [DUTY_W-1:0]         lim
    );
        logic signed [SPEED_W:0] vx;
        logic signed [SPEED_W:0] lp;
        logic signed [SPEED_W:0] ln;
        logic signed [SPEED_W:0] r;
        vx = (SPEED_W+1)'(v);
        lp = signed'({2'b00, lim});
        ln = -lp;
        if (vx > lp)
            r = lp;
        else if (vx < ln)
            r = ln;
        else
            r = vx;
        return SPEED_W'(r);
    endfunction

    function automatic logic signed [SPEED_W-1:0] ramp_toward(
        input logic signed [SPEED_W-1:0] act,
        input logic signed [SPEED_W-1:0] tgt,
        input logic                      ramp,
        input logic [DUTY_W-1:0]         step
    );
        logic signed [SPEED_W+1:0] ax;
        logic signed [SPEED_W+1:0] tx;
        logic signed [SPEED_W+1:0] sx;
        logic signed [SPEED_W+1:0] n;
        logic signed [SPEED_W-1:0] r;
        ax = (SPEED_W+2)'(act);
        tx = (SPEED_W+2)'(tgt);
        sx = signed'({3'b000, step});
        r  = tgt;
        if (ramp) begin
            if (ax < tx) begin
                n = ax + sx;
                r = (n < tx) ? SPEED_W'(n) : tgt;
            end
            else if (ax > tx) begin
                n = ax - sx;
                r = (n > tx) ? SPEED_W'(n) : tgt;
            end
            else begin
                r = act;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/core/dual_motor_ramp_brake_sequencer.sv
// Flow: an accepted request waits in the input register, is worked into the
// result register once that is free or being taken, then is on m_tvalid/m_tdata.
// Throughput: one request per cycle; a held result stalls s_tready only when
// both the input register and the result register are full.
// Reset: all motor, brake and command state cleared, duties zero, the
// configuration registers return to their default values.
// ----------------------------------------------------------------------------
// dual_motor_ramp_brake_sequencer
// Two H-bridge duty pairs with speed ramping, timed brake hold and a
// one-deep command slot completed by encoder travel or timeout.
// ----------------------------------------------------------------------------
module dual_motor_ramp_brake_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[31:0], left_value[47:32], right_value[63:48], ramp_enable[64],
    // brake_all[65], left_count[97:66], right_count[129:98],
    // left_rpm[145:130], right_rpm[161:146], demo_active[162], zero pad
    input  logic [dmrbs_pkg::IN_DATA_W-1:0]   s_tdata,
    // func[2:0]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // left_fwd_duty[14:0], left_rev_duty[29:15], right_fwd_duty[44:30],
    // right_rev_duty[59:45], left_braking[60], right_braking[61],
    // busy_res[62], queued[63], finish_event[65:64], zero pad
    output logic [dmrbs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [dmrbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmrbs_pkg::CFG_W-1:0]       cfg_data
);

    // configuration
    logic [14:0] max_pwm_reg;
    logic [14:0] ramp_step_reg;
    logic [15:0] brake_ms_reg;
    logic [14:0] stopped_rpm_reg;
    logic [30:0] min_pulses_reg;
    logic [15:0] timeout_ms_reg;

    // pipeline
    logic                            in_valid_reg;
    dmrbs_pkg::func_t                in_func_reg;
    logic [dmrbs_pkg::IN_DATA_W-1:0] in_data_reg;
    logic                            out_valid_reg;
    logic [dmrbs_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                            advance;

    // block state, index 0 left, 1 right
    logic signed [15:0] tgt_reg [2];
    logic signed [15:0] act_reg [2];
    logic               ramp_mode_reg;
    logic [1:0]         brake_reg;
    logic [31:0]        brake_start_reg [2];
    logic [14:0]        fwd_reg [2];
    logic [14:0]        rev_reg [2];
    logic               exec_reg;
    logic signed [15:0] cmd_spd_reg [2];
    logic signed [31:0] start_cnt_reg [2];
    logic [31:0]        cmd_time_reg;
    logic               next_valid_reg;
    logic signed [15:0] next_spd_reg [2];

    logic signed [15:0] tgt_next [2];
    logic signed [15:0] act_next [2];
    logic               ramp_mode_next;
    logic [1:0]         brake_next;
    logic [31:0]        brake_start_next [2];
    logic [14:0]        fwd_next [2];
    logic [14:0]        rev_next [2];
    logic               exec_next;
    logic signed [15:0] cmd_spd_next [2];
    logic signed [31:0] start_cnt_next [2];
    logic [31:0]        cmd_time_next;
    logic               next_valid_next;
    logic signed [15:0] next_spd_next [2];
    dmrbs_pkg::event_t  ev_next;

    // request fields
    logic [31:0]        now;
    logic signed [15:0] val_in [2];
    logic signed [31:0] cnt_in [2];
    logic signed [15:0] rpm_in [2];
    logic               ramp_en;
    logic               abs_brake;
    logic               demo;

    assign now       = in_data_reg[dmrbs_pkg::IN_NOW_LO +: 32];
    assign val_in[0] = in_data_reg[dmrbs_pkg::IN_LVAL_LO +: 16];
    assign val_in[1] = in_data_reg[dmrbs_pkg::IN_RVAL_LO +: 16];
    assign cnt_in[0] = in_data_reg[dmrbs_pkg::IN_LCNT_LO +: 32];
    assign cnt_in[1] = in_data_reg[dmrbs_pkg::IN_RCNT_LO +: 32];
    assign rpm_in[0] = in_data_reg[dmrbs_pkg::IN_LRPM_LO +: 16];
    assign rpm_in[1] = in_data_reg[dmrbs_pkg::IN_RRPM_LO +: 16];
    assign ramp_en   = in_data_reg[dmrbs_pkg::IN_RAMP_EN];
    assign abs_brake = in_data_reg[dmrbs_pkg::IN_ABS_BRK];
    assign demo      = in_data_reg[dmrbs_pkg::IN_DEMO];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pwm_reg     <= dmrbs_pkg::RST_MAX_PWM;
            ramp_step_reg   <= dmrbs_pkg::RST_RAMP_STEP;
            brake_ms_reg    <= dmrbs_pkg::RST_BRAKE_MS;
            stopped_rpm_reg <= dmrbs_pkg::RST_STOPPED_RPM;
            min_pulses_reg  <= dmrbs_pkg::RST_MIN_PULSES;
            timeout_ms_reg  <= dmrbs_pkg::RST_TIMEOUT_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmrbs_pkg::CFG_MAX_PWM:     max_pwm_reg     <= cfg_data[14:0];
                dmrbs_pkg::CFG_RAMP_STEP:   ramp_step_reg   <= cfg_data[14:0];
                dmrbs_pkg::CFG_BRAKE_MS:    brake_ms_reg    <= cfg_data[15:0];
                dmrbs_pkg::CFG_STOPPED_RPM: stopped_rpm_reg <= cfg_data[14:0];
                dmrbs_pkg::CFG_MIN_PULSES:  min_pulses_reg  <= cfg_data;
                dmrbs_pkg::CFG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic                      start;
        logic signed [15:0]        src [2];
        logic                      changed;
        logic                      met;
        logic                      tout;
        logic                      brk [2];
        logic signed [32:0]        diff;
        logic [32:0]               travel [2];
        logic signed [16:0]        rpm_x;
        logic [16:0]               rpm_abs;
        logic signed [15:0]        clamped [2];

        tgt_next         = tgt_reg;
        act_next         = act_reg;
        ramp_mode_next   = ramp_mode_reg;
        brake_next       = brake_reg;
        brake_start_next = brake_start_reg;
        fwd_next         = fwd_reg;
        rev_next         = rev_reg;
        exec_next        = exec_reg;
        cmd_spd_next     = cmd_spd_reg;
        start_cnt_next   = start_cnt_reg;
        cmd_time_next    = cmd_time_reg;
        next_valid_next  = next_valid_reg;
        next_spd_next    = next_spd_reg;
        ev_next          = dmrbs_pkg::EV_NONE;
        start            = 1'b0;
        src              = next_spd_reg;
        changed          = 1'b0;
        met              = 1'b0;
        tout             = 1'b0;
        brk[0]           = 1'b0;
        brk[1]           = 1'b0;
        diff             = '0;
        rpm_x            = '0;
        rpm_abs          = '0;

        for (int s = 0; s < 2; s++)
        begin
            clamped[s] = dmrbs_pkg::clamp_speed(val_in[s], max_pwm_reg);
            diff       = 33'(cnt_in[s]) - 33'(start_cnt_reg[s]);
            travel[s]  = (diff < 0) ? 33'(-diff) : 33'(diff);
        end

        case (in_func_reg)
            dmrbs_pkg::FUNC_TICK:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    if (brake_reg[s] && ((now - brake_start_reg[s]) >= {16'd0, brake_ms_reg}))
                    begin
                        fwd_next[s]   = '0;
                        rev_next[s]   = '0;
                        brake_next[s] = 1'b0;
                    end
                end
                changed = (act_reg[0] != tgt_reg[0]) || (act_reg[1] != tgt_reg[1]);
                for (int s = 0; s < 2; s++)
                begin
                    act_next[s] = dmrbs_pkg::ramp_toward(act_reg[s], tgt_reg[s],
                                                         ramp_mode_reg, ramp_step_reg);
                    if (changed)
                    begin
                        if (act_next[s] == 16'sd0)
                            brk[s] = 1'b1;
                        else if (act_next[s] > 16'sd0)
                        begin
                            fwd_next[s]   = act_next[s][14:0];
                            rev_next[s]   = '0;
                            brake_next[s] = 1'b0;
                        end
                        else
                        begin
                            fwd_next[s]   = '0;
                            rev_next[s]   = 15'(-act_next[s]);
                            brake_next[s] = 1'b0;
                        end
                    end
                end
            end
            dmrbs_pkg::FUNC_PROCESS:
            begin
                if (!demo)
                begin
                    if (!exec_reg)
                        start = next_valid_reg;
                    else
                    begin
                        met  = (travel[0] >= {2'b00, min_pulses_reg}) ||
                               (travel[1] >= {2'b00, min_pulses_reg});
                        tout = (now - cmd_time_reg) >= {16'd0, timeout_ms_reg};
                        if (cmd_spd_reg[0] == 16'sd0 && cmd_spd_reg[1] == 16'sd0)
                            ev_next = dmrbs_pkg::EV_DONE;
                        else if (tout)
                            ev_next = dmrbs_pkg::EV_TIMEOUT;
                        else if (met)
                            ev_next = dmrbs_pkg::EV_DONE;
                        if (ev_next != dmrbs_pkg::EV_NONE)
                        begin
                            exec_next = 1'b0;
                            start     = next_valid_reg;
                        end
                    end
                end
            end
            dmrbs_pkg::FUNC_COMMAND:
            begin
                if (!exec_reg)
                begin
                    start = 1'b1;
                    src   = clamped;
                end
                else
                begin
                    next_valid_next = 1'b1;
                    next_spd_next   = clamped;
                end
            end
            dmrbs_pkg::FUNC_RESET:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    tgt_next[s]       = '0;
                    act_next[s]       = '0;
                    cmd_spd_next[s]   = '0;
                    start_cnt_next[s] = '0;
                    next_spd_next[s]  = '0;
                    rpm_x             = 17'(rpm_in[s]);
                    rpm_abs           = (rpm_x < 0) ? 17'(-rpm_x) : 17'(rpm_x);
                    brk[s]            = abs_brake || (rpm_abs > {2'b00, stopped_rpm_reg});
                end
                exec_next       = 1'b0;
                cmd_time_next   = '0;
                next_valid_next = 1'b0;
            end
            dmrbs_pkg::FUNC_SPEEDS:
            begin
                tgt_next       = clamped;
                ramp_mode_next = ramp_en;
            end
            default: ;
        endcase

        for (int s = 0; s < 2; s++)
        begin
            if (brk[s])
            begin
                fwd_next[s]         = max_pwm_reg;
                rev_next[s]         = max_pwm_reg;
                brake_next[s]       = 1'b1;
                brake_start_next[s] = now;
            end
        end

        if (start)
        begin
            cmd_spd_next    = src;
            start_cnt_next  = cnt_in;
            cmd_time_next   = now;
            for (int s = 0; s < 2; s++)
                tgt_next[s] = dmrbs_pkg::clamp_speed(src[s], max_pwm_reg);
            ramp_mode_next  = 1'b1;
            exec_next       = 1'b1;
            next_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_func_reg    <= dmrbs_pkg::FUNC_TICK;
            out_valid_reg  <= 1'b0;
            ramp_mode_reg  <= 1'b0;
            brake_reg      <= '0;
            exec_reg       <= 1'b0;
            cmd_time_reg   <= '0;
            next_valid_reg <= 1'b0;
            for (int s = 0; s < 2; s++)
            begin
                tgt_reg[s]         <= '0;
                act_reg[s]         <= '0;
                brake_start_reg[s] <= '0;
                fwd_reg[s]         <= '0;
                rev_reg[s]         <= '0;
                cmd_spd_reg[s]     <= '0;
                start_cnt_reg[s]   <= '0;
                next_spd_reg[s]    <= '0;
            end
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                in_func_reg  <= dmrbs_pkg::func_t'(s_tuser);
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                tgt_reg         <= tgt_next;
                act_reg         <= act_next;
                ramp_mode_reg   <= ramp_mode_next;
                brake_reg       <= brake_next;
                brake_start_reg <= brake_start_next;
                fwd_reg         <= fwd_next;
                rev_reg         <= rev_next;
                exec_reg        <= exec_next;
                cmd_spd_reg     <= cmd_spd_next;
                start_cnt_reg   <= start_cnt_next;
                cmd_time_reg    <= cmd_time_next;
                next_valid_reg  <= next_valid_next;
                next_spd_reg    <= next_spd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
            in_data_reg <= s_tdata;
        if (advance)
            out_data_reg <= {6'd0, ev_next, next_valid_next, exec_next,
                             brake_next[1], brake_next[0],
                             rev_next[1], fwd_next[1], rev_next[0], fwd_next[0]};
    end

    a_queued_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        next_valid_reg |-> exec_reg)
        else $error("command slot full while no command runs");

    a_event_only_on_process: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (ev_next != dmrbs_pkg::EV_NONE)
            |-> (in_func_reg == dmrbs_pkg::FUNC_PROCESS) && exec_reg)
        else $error("finish event without a running command");

    a_brake_left_duty: assert property (@(posedge clk) disable iff (!rst_n)
        brake_reg[0] |-> (fwd_reg[0] == rev_reg[0]))
        else $error("left brake hold with unequal duties");

    a_brake_right_duty: assert property (@(posedge clk) disable iff (!rst_n)
        brake_reg[1] |-> (fwd_reg[1] == rev_reg[1]))
        else $error("right brake hold with unequal duties");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("request refused with a free stage");

endmodule

>>> tb/dual_motor_ramp_brake_sequencer_checker.sv
// ----------------------------------------------------------------------------
// dual_motor_ramp_brake_sequencer_checker
// Watches the request, result and register write channels of the motor
// sequencer. It tracks its own copy of speeds, brakes, duties and the command
// slot, predicts the duty and status word for each request, and compares
// every result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module dual_motor_ramp_brake_sequencer_checker
    import dmrbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        ev;
        logic              queued;
        logic              busy;
        logic              rbrk;
        logic              lbrk;
        logic [DUTY_W-1:0] rr;
        logic [DUTY_W-1:0] rf;
        logic [DUTY_W-1:0] lr;
        logic [DUTY_W-1:0] lf;
    } motor_status_t;

    logic [14:0] max_pwm;
    logic [14:0] ramp_step;
    logic [15:0] brake_ms;
    logic [14:0] stopped_rpm;
    logic [30:0] min_pulses;
    logic [15:0] timeout_ms;

    logic signed [SPEED_W-1:0] tgt_l, tgt_r, act_l, act_r;
    logic                      ramp_on;
    logic [1:0]                brk;
    logic [TIME_W-1:0]         brk_t0 [2];
    logic [DUTY_W-1:0]         duty [4];
    logic                      running;
    logic signed [SPEED_W-1:0] run_spd [2];
    logic signed [COUNT_W-1:0] base_cnt [2];
    logic [TIME_W-1:0]         run_t0;
    logic                      slot_full;
    logic signed [SPEED_W-1:0] slot_spd [2];

    motor_status_t status_q [$];
    int            mismatches;

    function automatic logic signed [SPEED_W-1:0] limit_speed(input logic signed [SPEED_W-1:0] v);
        int lim;
        int x;
        lim = int'(max_pwm);
        x = int'(v);
        if (x > lim)
            x = lim;
        else if (x < -lim)
            x = -lim;
        return 16'(x);
    endfunction

    // step computed in int so a large step never wraps
    function automatic logic signed [SPEED_W-1:0] step_speed(
        input logic signed [SPEED_W-1:0] cur,
        input logic signed [SPEED_W-1:0] goal,
        inout bit                        moved
    );
        int n;
        if (!ramp_on) begin
            if (cur != goal)
                moved = 1'b1;
            return goal;
        end
        if (cur < goal) begin
            moved = 1'b1;
            n = int'(cur) + int'(ramp_step);
            return (n < int'(goal)) ? 16'(n) : goal;
        end
        if (cur > goal) begin
            moved = 1'b1;
            n = int'(cur) - int'(ramp_step);
            return (n > int'(goal)) ? 16'(n) : goal;
        end
        return cur;
    endfunction

    task automatic hold_brake(input int side, input logic [TIME_W-1:0] now);
        duty[2*side]   = max_pwm;
        duty[2*side+1] = max_pwm;
        brk[side]      = 1'b1;
        brk_t0[side]   = now;
    endtask

    task automatic apply_drive(input int side, input logic signed [SPEED_W-1:0] spd,
                               input logic [TIME_W-1:0] now);
        int mag;
        mag = int'(spd);
        if (mag == 0) begin
            hold_brake(side, now);
        end
        else if (mag > 0) begin
            duty[2*side+1] = '0;
            duty[2*side]   = mag[14:0];
            brk[side]      = 1'b0;
        end
        else begin
            mag = -mag;
            duty[2*side]   = '0;
            duty[2*side+1] = mag[14:0];
            brk[side]      = 1'b0;
        end
    endtask

    task automatic update_tick(input logic [TIME_W-1:0] now);
        bit          moved;
        logic [31:0] held;
        moved = 1'b0;
        for (int s = 0; s < 2; s++) begin
            held = now - brk_t0[s];
            if (brk[s] && held >= 32'(brake_ms)) begin
                duty[2*s]   = '0;
                duty[2*s+1] = '0;
                brk[s]      = 1'b0;
            end
        end
        act_l = step_speed(act_l, tgt_l, moved);
        act_r = step_speed(act_r, tgt_r, moved);
        if (moved) begin
            apply_drive(0, act_l, now);
            apply_drive(1, act_r, now);
        end
    endtask

    task automatic begin_command(input logic signed [SPEED_W-1:0] l, input logic signed [SPEED_W-1:0] r,
                                 input logic signed [COUNT_W-1:0] lc,
                                 input logic signed [COUNT_W-1:0] rc,
                                 input logic [TIME_W-1:0] now);
        run_spd[0]  = l;
        run_spd[1]  = r;
        base_cnt[0] = lc;
        base_cnt[1] = rc;
        run_t0      = now;
        tgt_l       = limit_speed(l);
        tgt_r       = limit_speed(r);
        ramp_on     = 1'b1;
        running     = 1'b1;
        slot_full   = 1'b0;
    endtask

    task automatic advance_sequencer(input logic [2:0] fn, input logic [IN_DATA_W-1:0] d,
                                     output motor_status_t res);
        logic [TIME_W-1:0]         now;
        logic [TIME_W-1:0]         elapsed;
        logic signed [SPEED_W-1:0] lv, rv, lrpm, rrpm;
        logic signed [COUNT_W-1:0] lc, rc;
        logic                      ramp_en, abs_brk, demo;
        logic [1:0]                ev;
        longint                    dl, dr;
        int                        al, ar;
        bit                        done, met, tout;
        now     = d[IN_NOW_LO +: TIME_W];
        lv      = d[IN_LVAL_LO +: SPEED_W];
        rv      = d[IN_RVAL_LO +: SPEED_W];
        ramp_en = d[IN_RAMP_EN];
        abs_brk = d[IN_ABS_BRK];
        lc      = d[IN_LCNT_LO +: COUNT_W];
        rc      = d[IN_RCNT_LO +: COUNT_W];
        lrpm    = d[IN_LRPM_LO +: SPEED_W];
        rrpm    = d[IN_RRPM_LO +: SPEED_W];
        demo    = d[IN_DEMO];
        ev      = EV_NONE;
        case (fn)
            FUNC_TICK: update_tick(now);
            FUNC_PROCESS: begin
                if (!demo) begin
                    if (!running) begin
                        if (slot_full)
                            begin_command(slot_spd[0], slot_spd[1], lc, rc, now);
                    end
                    else begin
                        done = 1'b0;
                        if (run_spd[0] == 0 && run_spd[1] == 0) begin
                            done = 1'b1;
                            ev   = EV_DONE;
                        end
                        else begin
                            dl = longint'(lc) - longint'(base_cnt[0]);
                            dr = longint'(rc) - longint'(base_cnt[1]);
                            if (dl < 0)
                                dl = -dl;
                            if (dr < 0)
                                dr = -dr;
                            met     = (dl >= longint'(min_pulses)) || (dr >= longint'(min_pulses));
                            elapsed = now - run_t0;
                            tout    = elapsed >= 32'(timeout_ms);
                            // timeout takes priority over travel
                            if (met || tout) begin
                                done = 1'b1;
                                ev   = tout ? EV_TIMEOUT : EV_DONE;
                            end
                        end
                        if (done) begin
                            running = 1'b0;
                            if (slot_full)
                                begin_command(slot_spd[0], slot_spd[1], lc, rc, now);
                        end
                    end
                end
            end
            FUNC_COMMAND: begin
                if (!running) begin
                    begin_command(limit_speed(lv), limit_speed(rv), lc, rc, now);
                end
                else begin
                    slot_full   = 1'b1;
                    slot_spd[0] = limit_speed(lv);
                    slot_spd[1] = limit_speed(rv);
                end
            end
            FUNC_RESET: begin
                tgt_l       = '0;
                tgt_r       = '0;
                act_l       = '0;
                act_r       = '0;
                running     = 1'b0;
                run_spd     = '{default: '0};
                base_cnt    = '{default: '0};
                run_t0      = '0;
                slot_full   = 1'b0;
                slot_spd    = '{default: '0};
                if (abs_brk) begin
                    hold_brake(0, now);
                    hold_brake(1, now);
                end
                else begin
                    al = int'(lrpm);
                    ar = int'(rrpm);
                    if (al < 0)
                        al = -al;
                    if (ar < 0)
                        ar = -ar;
                    if (al > int'(stopped_rpm))
                        hold_brake(0, now);
                    if (ar > int'(stopped_rpm))
                        hold_brake(1, now);
                end
            end
            FUNC_SPEEDS: begin
                tgt_l   = limit_speed(lv);
                tgt_r   = limit_speed(rv);
                ramp_on = ramp_en;
            end
            default: ;
        endcase
        res.lf     = duty[0];
        res.lr     = duty[1];
        res.rf     = duty[2];
        res.rr     = duty[3];
        res.lbrk   = brk[0];
        res.rbrk   = brk[1];
        res.busy   = running;
        res.queued = slot_full;
        res.ev     = ev;
    endtask

    function automatic int field_differs(input string name, input int want, input int got);
        if (want == got)
            return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        motor_status_t want;
        motor_status_t got;
        if (!rst_n) begin
            max_pwm     = RST_MAX_PWM;
            ramp_step   = RST_RAMP_STEP;
            brake_ms    = RST_BRAKE_MS;
            stopped_rpm = RST_STOPPED_RPM;
            min_pulses  = RST_MIN_PULSES;
            timeout_ms  = RST_TIMEOUT_MS;
            tgt_l       = '0;
            tgt_r       = '0;
            act_l       = '0;
            act_r       = '0;
            ramp_on     = 1'b0;
            brk         = '0;
            brk_t0      = '{default: '0};
            duty        = '{default: '0};
            running     = 1'b0;
            run_spd     = '{default: '0};
            base_cnt    = '{default: '0};
            run_t0      = '0;
            slot_full   = 1'b0;
            slot_spd    = '{default: '0};
            status_q.delete();
            mismatches  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MAX_PWM:     max_pwm     = cfg_data[14:0];
                    CFG_RAMP_STEP:   ramp_step   = cfg_data[14:0];
                    CFG_BRAKE_MS:    brake_ms    = cfg_data[15:0];
                    CFG_STOPPED_RPM: stopped_rpm = cfg_data[14:0];
                    CFG_MIN_PULSES:  min_pulses  = cfg_data[30:0];
                    CFG_TIMEOUT_MS:  timeout_ms  = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[65:0];
                if (status_q.size() == 0) begin
                    $display("%0t: result with nothing outstanding, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end
                else begin
                    want = status_q.pop_front();
                    mismatches += field_differs("left_fwd_duty", want.lf, got.lf);
                    mismatches += field_differs("left_rev_duty", want.lr, got.lr);
                    mismatches += field_differs("right_fwd_duty", want.rf, got.rf);
                    mismatches += field_differs("right_rev_duty", want.rr, got.rr);
                    mismatches += field_differs("left_braking", want.lbrk, got.lbrk);
                    mismatches += field_differs("right_braking", want.rbrk, got.rbrk);
                    mismatches += field_differs("busy_res", want.busy, got.busy);
                    mismatches += field_differs("queued", want.queued, got.queued);
                    mismatches += field_differs("finish_event", want.ev, got.ev);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_sequencer(s_tuser, s_tdata, want);
                status_q.push_back(want);
            end
            fail_count <= mismatches;
            pending    <= status_q.size();
        end
    end

endmodule

>>> tb/dual_motor_ramp_brake_sequencer_tb.sv
// ----------------------------------------------------------------------------
// dual_motor_ramp_brake_sequencer_tb
// Drives directed and random motor requests into the sequencer under several
// register settings and handshake idling patterns, including a long result
// stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module dual_motor_ramp_brake_sequencer_tb;
    import dmrbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    int                    fail_count;
    int                    pending;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_seq;
    int quiet_cycles;

    logic [TIME_W-1:0]         world_ms;
    logic signed [COUNT_W-1:0] world_lc;
    logic signed [COUNT_W-1:0] world_rc;

    dual_motor_ramp_brake_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dual_motor_ramp_brake_sequencer_checker status_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input logic [2:0] fn, input logic [TIME_W-1:0] now,
                                input logic signed [SPEED_W-1:0] lv,
                                input logic signed [SPEED_W-1:0] rv,
                                input logic ramp_en, input logic abs_brk,
                                input logic signed [COUNT_W-1:0] lc,
                                input logic signed [COUNT_W-1:0] rc,
                                input logic signed [SPEED_W-1:0] lrpm,
                                input logic signed [SPEED_W-1:0] rrpm,
                                input logic demo);
        logic [IN_DATA_W-1:0] d;
        d                           = '0;
        d[IN_NOW_LO +: TIME_W]      = now;
        d[IN_LVAL_LO +: SPEED_W]    = lv;
        d[IN_RVAL_LO +: SPEED_W]    = rv;
        d[IN_RAMP_EN]               = ramp_en;
        d[IN_ABS_BRK]               = abs_brk;
        d[IN_LCNT_LO +: COUNT_W]    = lc;
        d[IN_RCNT_LO +: COUNT_W]    = rc;
        d[IN_LRPM_LO +: SPEED_W]    = lrpm;
        d[IN_RRPM_LO +: SPEED_W]    = rrpm;
        d[IN_DEMO]                  = demo;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic program_registers(input logic [CFG_W-1:0] pwm, input logic [CFG_W-1:0] step,
                                     input logic [CFG_W-1:0] brake,
                                     input logic [CFG_W-1:0] stopped,
                                     input logic [CFG_W-1:0] pulses,
                                     input logic [CFG_W-1:0] tmo);
        logic [CFG_W-1:0]     vals [6];
        logic [CFG_IDX_W-1:0] idx [6];
        vals = '{pwm, step, brake, stopped, pulses, tmo};
        idx  = '{CFG_MAX_PWM, CFG_RAMP_STEP, CFG_BRAKE_MS, CFG_STOPPED_RPM,
                 CFG_MIN_PULSES, CFG_TIMEOUT_MS};
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic program_moderate_registers();
        program_registers($urandom_range(300, 1), $urandom_range(40, 1), $urandom_range(60, 0),
                          $urandom_range(40, 0), $urandom_range(150, 0), $urandom_range(400, 0));
    endtask

    function automatic logic signed [SPEED_W-1:0] rand_speed();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return '0;
        if (pick < 45)
            return 16'($urandom());
        return 16'(int'($urandom_range(800)) - 400);
    endfunction

    function automatic logic signed [SPEED_W-1:0] rand_rpm();
        if ($urandom_range(99) < 30)
            return 16'($urandom());
        return 16'(int'($urandom_range(120)) - 60);
    endfunction

    task automatic run_phase(input int count, input bit squeeze);
        int         pick;
        logic [2:0] fn;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 35)
                fn = FUNC_TICK;
            else if (pick < 60)
                fn = FUNC_PROCESS;
            else if (pick < 75)
                fn = FUNC_COMMAND;
            else if (pick < 80)
                fn = FUNC_RESET;
            else if (pick < 95)
                fn = FUNC_SPEEDS;
            else
                fn = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
            world_ms += $urandom_range(15);
            if ($urandom_range(199) == 0)
                world_ms = $urandom();
            world_lc = world_lc + int'($urandom_range(30)) - 10;
            world_rc = world_rc + int'($urandom_range(30)) - 20;
            if ($urandom_range(99) < 2)
                world_lc = $urandom();
            if ($urandom_range(99) < 2)
                world_rc = $urandom();
            if (squeeze && k == count / 2)
                hold_seq++;
            send_request(fn, world_ms, rand_speed(), rand_speed(), $urandom_range(1),
                         $urandom_range(1), world_lc, world_rc, rand_rpm(), rand_rpm(),
                         ($urandom_range(9) == 0));
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = FUNC_TICK;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MAX_PWM;
        cfg_data      = '0;
        quiet_cycles  = 0;
        hold_seq      = 0;
        send_idle_pct = 19;
        recv_idle_pct = 68;
        world_ms      = '0;
        world_lc      = '0;
        world_rc      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset
        send_request(FUNC_UNUSED_LO, '1, -1, -1, 1, 1, -1, -1, -1, -1, 1);
        send_request(FUNC_UNUSED_HI, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_SPEEDS, 0, 32767, -32768, 1, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_SPEEDS, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 104, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 105, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_COMMAND, 200, 100, -100, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_COMMAND, 201, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_PROCESS, 202, 0, 0, 0, 0, 5, -5, 0, 0, 0);
        send_request(FUNC_PROCESS, 203, 0, 0, 0, 0, -10, 0, 0, 0, 0);
        send_request(FUNC_PROCESS, 204, 0, 0, 0, 0, -10, 0, 0, 0, 0);
        // travel and timeout on the same request
        send_request(FUNC_COMMAND, 300, 50, 50, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_PROCESS, 1300, 0, 0, 0, 0, 10, 0, 0, 0, 0);
        send_request(FUNC_COMMAND, 1400, 20, 20, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_PROCESS, 5000, 0, 0, 0, 0, 1000, 1000, 0, 0, 1);
        send_request(FUNC_RESET, 5001, 0, 0, 0, 0, 0, 0, 2, -1, 0);
        // brake hold across the time wrap
        send_request(FUNC_RESET, 32'hFFFF_FFF0, 0, 0, 0, 1, 0, 0, -32768, 32767, 0);
        send_request(FUNC_TICK, 32'h0000_0060, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // zero clamp limit, everything else at its low end
        program_registers(0, 1, 0, 0, 0, 0);
        send_request(FUNC_SPEEDS, 10, 1000, -1000, 1, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_RESET, 11, 0, 0, 0, 0, 0, 0, 1, -1, 0);
        send_request(FUNC_COMMAND, 12, 5, 5, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_PROCESS, 13, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        program_registers(1, 32767, 65535, 32767, 31'h7FFF_FFFF, 0);
        send_request(FUNC_SPEEDS, 20, 32767, -32768, 1, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 21, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_COMMAND, 22, 9, -9, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0);
        send_request(FUNC_PROCESS, 22, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0);

        // full-scale steps overshooting the target
        program_registers(32767, 32767, 65535, 32767, 31'h7FFF_FFFF, 65535);
        send_request(FUNC_SPEEDS, 30, 32767, -32768, 1, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_SPEEDS, 32, -32767, 32767, 1, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 33, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_request(FUNC_TICK, 34, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        program_moderate_registers();
        world_ms = 32'd100;
        run_phase(330, 1'b0);

        send_idle_pct = 68;
        recv_idle_pct = 19;
        program_registers(32767, 32767, 65535, 32767, 31'h7FFF_FFFF, 65535);
        world_ms = 32'hFFFF_FC00;
        run_phase(170, 1'b0);
        program_moderate_registers();
        run_phase(170, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_moderate_registers();
        run_phase(330, 1'b1);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/dmrbs_pkg.sv
rtl/core/dual_motor_ramp_brake_sequencer.sv
tb/dual_motor_ramp_brake_sequencer_checker.sv
tb/dual_motor_ramp_brake_sequencer_tb.sv
